// ----- rtl/missing_chunk_set_table_macros.svh -----
// ---------------------------------------------------------------------------
// Missing chunk set table assertion macros
// Shared property wrappers for the table's checker.
// ---------------------------------------------------------------------------
`ifndef MISSING_CHUNK_SET_TABLE_MACROS_SVH
`define MISSING_CHUNK_SET_TABLE_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define MCST_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked property that also holds through reset.
`define MCST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mcst_pkg.sv -----
// ---------------------------------------------------------------------------
// Missing chunk set table package
// Field widths, operation and status codes shared across the project.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcst_pkg;

  localparam int unsigned CHUNK_W           = 32;
  localparam int unsigned OP_W              = 2;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned SLOT_W            = 6;
  localparam int unsigned DEF_TABLE_ENTRIES = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

endpackage

// ----- rtl/mcst_req_if.sv -----
// ---------------------------------------------------------------------------
// Missing chunk set table request channel
// Valid/ready channel carrying an operation and a chunk number.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcst_req_if;
  logic                         valid;
  logic                         ready;
  logic [mcst_pkg::OP_W-1:0]    operation;
  logic [mcst_pkg::CHUNK_W-1:0] chunk_number;

  modport source (output valid, output operation, output chunk_number, input ready);
  modport sink   (input valid, input operation, input chunk_number, output ready);
endinterface

// ----- rtl/mcst_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Missing chunk set table response channel
// Valid/ready channel carrying status, hit flag and slot index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mcst_pkg::STATUS_W-1:0] status;
  logic                          hit;
  logic [mcst_pkg::SLOT_W-1:0]   slot_index;

  modport source (output valid, output status, output hit, output slot_index, input ready);
  modport sink   (input valid, input status, input hit, input slot_index, output ready);
endinterface

// ----- rtl/missing_chunk_set_table.sv -----
// ---------------------------------------------------------------------------
// Missing chunk set table
// Set of chunk numbers with add, remove, find and clear, held in one RAM.
// ---------------------------------------------------------------------------
// Usage:
//   request  : valid/ready transaction with operation and chunk_number.
//   response : valid/ready transaction with status, hit and slot_index;
//              exactly one response per request, in order.
//   Each slot is one RAM word {valid, chunk}. Add, remove and find walk the
//   RAM from slot 0 upward, one read a cycle through a registered read, and
//   note the lowest matching slot and the lowest free slot. The decide
//   state then writes back at most one word and builds the result.
//   Requests are taken one at a time: request.ready is high only in the
//   idle state, which follows the response state once the result has gone
//   into the response register. Clear rewrites every word, then passes its
//   result through the response state the same way.
//   Reset: a clearing pass writes every word invalid; request.ready stays
//   low until it ends.
//   Stall: a result waits in the response register while response.ready is
//   low; the block takes the next request during that wait and holds the
//   finished result of that one until the register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module missing_chunk_set_table #(
  parameter int unsigned TABLE_ENTRIES = mcst_pkg::DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  mcst_req_if.sink    request,
  mcst_rsp_if.source  response
);
  import mcst_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CLEAR,
    S_RESP
  } state_t;

  // Table RAM: bit CHUNK_W is the valid mark, the rest the chunk number.
  logic [CHUNK_W:0] mem [TABLE_ENTRIES];

  state_t              state;
  op_t                 op;
  logic [CHUNK_W-1:0]  key;

  // Read pipeline
  logic [IDX_W-1:0]    scan_addr;
  logic                issue_done;
  logic                rd_valid;
  logic                rd_last;
  logic [IDX_W-1:0]    rd_slot;
  logic [CHUNK_W:0]    rd_data;

  // Scan results
  logic                match_found;
  logic [IDX_W-1:0]    match_slot;
  logic                free_found;
  logic [IDX_W-1:0]    free_slot;

  logic [IDX_W-1:0]    sweep_addr;

  // Result waiting for the response register
  status_t             res_status;
  logic                res_hit;
  logic [IDX_W-1:0]    res_slot;

  // Response register
  logic                rsp_valid;
  status_t             rsp_status;
  logic                rsp_hit;
  logic [SLOT_W-1:0]   rsp_slot;

  // Write port
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [CHUNK_W:0]    mem_wdata;

  logic [EXT_W-1:0]    res_slot_ext;

  assign request.ready       = (state == S_IDLE);
  assign response.valid      = rsp_valid;
  assign response.status     = rsp_status;
  assign response.hit        = rsp_hit;
  assign response.slot_index = rsp_slot;

  // Low bits of the slot number go out; narrow tables extend with zeros.
  assign res_slot_ext = EXT_W'(res_slot);

  // Write-back: clearing sweeps, or the one word that add or remove changes.
  // Read data is used only in the scan, and no write happens in the scan.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = '0;
    case (state)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_DECIDE: begin
        if (op == OP_ADD && !match_found && free_found) begin
          mem_we    = 1'b1;
          mem_waddr = free_slot;
          mem_wdata = {1'b1, key};
        end else if (op == OP_REMOVE && match_found) begin
          mem_we    = 1'b1;
          mem_waddr = match_slot;
          mem_wdata = {1'b0, key};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep_addr  <= '0;
      scan_addr   <= '0;
      issue_done  <= 1'b1;
      rd_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      // Load a finished result once the register frees; drop one once taken.
      if (state == S_RESP && (!rsp_valid || response.ready)) begin
        rsp_valid  <= 1'b1;
        rsp_status <= res_status;
        rsp_hit    <= res_hit;
        rsp_slot   <= res_slot_ext[SLOT_W-1:0];
      end else if (rsp_valid && response.ready) begin
        rsp_valid <= 1'b0;
      end

      // Issue one read per cycle during the scan.
      if (state == S_SCAN && !issue_done) begin
        rd_valid <= 1'b1;
        rd_slot  <= scan_addr;
        rd_last  <= (scan_addr == LAST_IDX);
        if (scan_addr == LAST_IDX) begin
          issue_done <= 1'b1;
        end else begin
          scan_addr <= scan_addr + 1'b1;
        end
      end else begin
        rd_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (request.valid) begin
            op          <= op_t'(request.operation);
            key         <= request.chunk_number;
            scan_addr   <= '0;
            issue_done  <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            sweep_addr  <= '0;
            if (op_t'(request.operation) == OP_CLEAR) begin
              state <= S_CLEAR;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (rd_valid) begin
            // Keep the lowest hit and the lowest hole.
            if (rd_data[CHUNK_W] && rd_data[CHUNK_W-1:0] == key && !match_found) begin
              match_found <= 1'b1;
              match_slot  <= rd_slot;
            end
            if (!rd_data[CHUNK_W] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= rd_slot;
            end
            if (rd_last) begin
              state <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          if (match_found) begin
            res_status <= ST_OK;
            res_hit    <= 1'b1;
            res_slot   <= match_slot;
          end else if (op == OP_ADD && free_found) begin
            res_status <= ST_OK;
            res_hit    <= 1'b0;
            res_slot   <= free_slot;
          end else if (op == OP_ADD) begin
            res_status <= ST_FULL;
            res_hit    <= 1'b0;
            res_slot   <= '0;
          end else begin
            res_status <= ST_NOT_FOUND;
            res_hit    <= 1'b0;
            res_slot   <= '0;
          end
          state <= S_RESP;
        end

        S_CLEAR: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_IDX) begin
            res_status <= ST_OK;
            res_hit    <= 1'b0;
            res_slot   <= '0;
            state      <= S_RESP;
          end
        end

        S_RESP: begin
          // Hold until the response register is free.
          if (!rsp_valid || response.ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/mcst_checker.sv -----
// ---------------------------------------------------------------------------
// Missing chunk set table checker
// Port-level properties of the table, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "missing_chunk_set_table_macros.svh"

module mcst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic [mcst_pkg::STATUS_W-1:0] out_status,
  input logic                          out_hit,
  input logic [mcst_pkg::SLOT_W-1:0]   out_slot
);
  import mcst_pkg::*;

  // The clearing pass follows reset, so no request is taken right after it.
  `MCST_ASSERT_ALWAYS(a_no_ready_after_rst, clk, rst |=> !in_ready, "ready right after reset")

  // One transaction at a time: a taken request closes the input.
  `MCST_ASSERT(a_one_at_a_time, clk, rst, (in_valid && in_ready) |=> !in_ready, "request overlap")

  // Failed add, remove or find carries no hit and no slot.
  `MCST_ASSERT(a_fail_no_slot, clk, rst, (out_valid && out_status != ST_OK) |-> (!out_hit && out_slot == '0), "fail with slot")

  // A hit always reports success.
  `MCST_ASSERT(a_hit_is_ok, clk, rst, (out_valid && out_hit) |-> (out_status == ST_OK), "hit without success")

endmodule

bind missing_chunk_set_table mcst_checker u_mcst_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (request.valid),
  .in_ready   (request.ready),
  .out_valid  (response.valid),
  .out_status (response.status),
  .out_hit    (response.hit),
  .out_slot   (response.slot_index)
);

// ----- tb/missing_chunk_set_table_test.sv -----
// ---------------------------------------------------------------------------
// Missing chunk set table testbench
// Drives add, remove, find and clear transactions with random idle gaps on
// both channels, predicts each response from a mirror of the table, and
// compares every response field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module missing_chunk_set_table_test;
  import mcst_pkg::*;

  localparam int unsigned TABLE_ENTRIES   = DEF_TABLE_ENTRIES;
  localparam int          RANDOM_ITEMS    = 1130;
  // Response count at which the receiver stops taking results for a while.
  localparam int          PRESSURE_AT     = 200;
  localparam int          HOLD_OFF_CYCLES = 600;
  // Cycles with no transaction on either channel before the run is abandoned.
  // The slowest correct stretch comes with the receiver's hold-off, far below this.
  localparam int          IDLE_LIMIT      = 4000;
  localparam int          POOL_MAX        = 100;

  // One expected response.
  typedef struct packed {
    status_t           status;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } table_result_t;

  // Mirror of the table contents plus the queue of responses still owed.
  class chunk_set_tracker;
    bit                 occupied [TABLE_ENTRIES];
    logic [CHUNK_W-1:0] stored   [TABLE_ENTRIES];
    table_result_t      pending_results [$];
    int                 error_count;

    function new();
      error_count = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    // Apply one accepted request to the mirror and queue its response.
    function void record_request(op_t op, logic [CHUNK_W-1:0] number);
      int            match;
      int            vacancy;
      table_result_t r;
      match    = -1;
      vacancy  = -1;
      r.status = ST_OK;
      r.hit    = 1'b0;
      r.slot   = '0;
      if (op == OP_CLEAR) begin
        foreach (occupied[i]) occupied[i] = 1'b0;
      end else begin
        // Walk downward so the last hit seen is the lowest slot.
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
          if (occupied[i] && stored[i] == number) match = i;
          if (!occupied[i]) vacancy = i;
        end
        if (match >= 0) begin
          r.hit  = 1'b1;
          r.slot = match[SLOT_W-1:0];
          if (op == OP_REMOVE) occupied[match] = 1'b0;
        end else if (op == OP_ADD) begin
          if (vacancy >= 0) begin
            occupied[vacancy] = 1'b1;
            stored[vacancy]   = number;
            r.slot            = vacancy[SLOT_W-1:0];
          end else begin
            r.status = ST_FULL;
          end
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      pending_results.push_back(r);
    endfunction

    // Compare one accepted response with the oldest one owed.
    function void check_response(logic [STATUS_W-1:0] status, logic hit,
                                 logic [SLOT_W-1:0] slot);
      table_result_t want;
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding");
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        error_count++;
      end
      if (hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, hit);
        error_count++;
      end
      if (slot !== want.slot) begin
        $error("slot_index: expected %0d, got %0d", want.slot, slot);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  mcst_req_if req_ch ();
  mcst_rsp_if rsp_ch ();

  missing_chunk_set_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .response(rsp_ch)
  );

  chunk_set_tracker tracker = new();

  // When set, the sender offers back to back with no idle cycles.
  bit sender_calm;
  int responses_seen;

  always #1 clk = ~clk;

  // Idle length: mostly none or short, now and then long enough to span
  // a whole table scan.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // Random chunk number: hug both ends of the range now and then.
  function automatic logic [CHUNK_W-1:0] random_chunk();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Offer one request after an optional gap and hold it until accepted.
  // Entered and left just after a falling edge.
  task automatic send_request(op_t op, logic [CHUNK_W-1:0] number);
    int gap;
    gap = sender_calm ? 0 : idle_length();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.chunk_number <= number;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.record_request(op, number);
    @(negedge clk);
  endtask

  // Response side: stall at random, hold off once for a long stretch so the
  // block fills up and stalls its request channel, check each transaction.
  initial begin : response_sink
    int stall;
    bit calm;
    bit pressed;
    calm    = 1'b0;
    pressed = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (responses_seen % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!pressed && responses_seen == PRESSURE_AT) begin
        pressed = 1'b1;
        stall   = HOLD_OFF_CYCLES;
      end else begin
        stall = calm ? 0 : idle_length();
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      tracker.check_response(rsp_ch.status, rsp_ch.hit, rsp_ch.slot_index);
      responses_seen++;
      @(negedge clk);
    end
  end

  // Abandon the run when neither channel moves a transaction for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("missing_chunk_set_table_test: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CHUNK_W-1:0] pool [POOL_MAX];
    int                 pool_size;
    int                 burst_len;
    int                 add_pct;
    int                 remove_pct;
    int                 clear_pct;
    int                 roll;
    int                 sent;
    op_t                op;
    logic [CHUNK_W-1:0] number;

    // Drive every input to a known value from time zero.
    clk                 = 1'b0;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.operation    = OP_ADD;
    req_ch.chunk_number = '0;
    rsp_ch.ready        = 1'b0;
    sender_calm         = 1'b0;
    responses_seen      = 0;

    // Hold reset, then release it at a falling edge. The block then
    // runs its clearing pass with request.ready low; send_request waits.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: lookups on the empty table, both ends of the number range,
    // an add of a present number, lowest-free-slot reuse after a remove,
    // a double remove, and clear with the number field at both extremes.
    send_request(OP_FIND,   32'h1234_5678);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_ADD,    32'h0000_0000);
    send_request(OP_ADD,    32'hFFFF_FFFF);
    send_request(OP_ADD,    32'h0000_0000);
    send_request(OP_FIND,   32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_FIND,   32'h0000_0000);
    send_request(OP_ADD,    32'hA5A5_A5A5);
    send_request(OP_ADD,    32'h5A5A_5A5A);
    send_request(OP_REMOVE, 32'h5A5A_5A5A);
    send_request(OP_REMOVE, 32'h5A5A_5A5A);
    send_request(OP_FIND,   32'hA5A5_A5A5);
    send_request(OP_CLEAR,  32'hFFFF_FFFF);
    send_request(OP_FIND,   32'hFFFF_FFFF);
    send_request(OP_ADD,    32'h0000_0001);
    send_request(OP_CLEAR,  32'h0000_0000);
    send_request(OP_FIND,   32'h0000_0001);

    // Random bursts. A fill burst draws adds from a pool larger than the
    // table so it runs full and exercises the full case alongside hits;
    // a churn burst mixes all operations over a small pool so removes and
    // finds mostly hit. About one number in ten is drawn from outside the
    // pool as noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        pool_size  = $urandom_range(TABLE_ENTRIES + 2, POOL_MAX);
        burst_len  = $urandom_range(150, 260);
        add_pct    = 85;
        remove_pct = 5;
        clear_pct  = 0;
      end else begin
        pool_size  = $urandom_range(2, 48);
        burst_len  = $urandom_range(20, 120);
        add_pct    = $urandom_range(20, 60);
        remove_pct = $urandom_range(10, 40);
        clear_pct  = 2;
      end
      for (int k = 0; k < pool_size; k++) pool[k] = random_chunk();
      sender_calm = ($urandom_range(0, 4) == 0);

      for (int n = 0; n < burst_len && sent < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < clear_pct) op = OP_CLEAR;
        else if (roll < clear_pct + add_pct) op = OP_ADD;
        else if (roll < clear_pct + add_pct + remove_pct) op = OP_REMOVE;
        else op = OP_FIND;
        if ($urandom_range(0, 9) == 0) number = random_chunk();
        else number = pool[$urandom_range(0, pool_size - 1)];
        send_request(op, number);
        sent++;
      end
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every owed response, then keep the clock running so
    // a stray extra response would still be caught.
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    if (tracker.error_count == 0) begin
      $display("missing_chunk_set_table_test: clean");
    end else begin
      $display("missing_chunk_set_table_test: errors");
    end
    $finish;
  end

endmodule
